[design/mdvm_pkg.sv]
// Shared operation codes, register indexes and field widths for the drone and click mixer.
package mdvm_pkg;

   localparam logic [2:0] OP_RENDER      = 3'd0;
   localparam logic [2:0] OP_PUSH        = 3'd1;
   localparam logic [2:0] OP_CLEAR       = 3'd2;
   localparam logic [2:0] OP_DRONE_START = 3'd3;
   localparam logic [2:0] OP_DRONE_STOP  = 3'd4;

   localparam logic [2:0] REG_METRONOME_ENABLE = 3'd0;
   localparam logic [2:0] REG_TICK_INCREMENT   = 3'd1;
   localparam logic [2:0] REG_BEATS_PER_BAR    = 3'd2;
   localparam logic [2:0] REG_DRONE_INCREMENT  = 3'd3;
   localparam logic [2:0] REG_DRONE_LEVEL      = 3'd4;

   localparam int FILL_W      = 19;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam logic [9:0]  DRONE_LEVEL_MAX = 10'd1000;
   localparam logic [25:0] TICK_INC_RESET  = 26'd10737;
   localparam logic [4:0]  BEATS_RESET     = 5'd4;
   localparam logic [9:0]  LEVEL_RESET     = 10'd400;
   localparam logic [4:0]  BAR_MAX         = 5'd16;

endpackage

[design/metronome_drone_voice_mixer_core.sv]
// Top level of the click, drone and voice mixer: sequencer, voice FIFO memory and sine ROM.
// A render beat passes the address, pipeline and done states before its result is loaded;
// other operations load their result on acceptance. The render path is set by two sine ROM
// reads through one registered port and a shared three-stage multiply and constant-divide
// pipeline. A new beat is taken in the cycle the previous result leaves, when the block is
// not rendering. Reset is synchronous and clears control and oscillator state.
module metronome_drone_voice_mixer_core #(
   parameter int VOICE_DEPTH    = 262144,
   parameter int SINE_ADDR_BITS = 10,
   parameter int CLICK_STEPS    = 100
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_operation,
   input  logic signed [15:0]                   req_voice_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [15:0]                   rsp_mix_sample,
   output logic                                 rsp_push_accepted,
   output logic                                 rsp_tick_fired,
   output logic                                 rsp_on_downbeat,
   output logic                                 rsp_drone_running,
   output logic [mdvm_pkg::FILL_W-1:0]          rsp_voice_fill,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mdvm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [mdvm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [mdvm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import mdvm_pkg::*;

   // Derived sizes. The pointer indexes the voice memory, the count can hold the depth.
   localparam int PTR_W     = (VOICE_DEPTH > 1) ? $clog2(VOICE_DEPTH) : 1;
   localparam int CNT_W     = $clog2(VOICE_DEPTH + 1);
   localparam int ROM_SIZE  = 1 << SINE_ADDR_BITS;
   localparam int QUARTER   = ROM_SIZE / 4;
   localparam int CLICK_DEN = 100 * CLICK_STEPS;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(VOICE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(VOICE_DEPTH);
   localparam logic [6:0] ENV_START = 7'(CLICK_STEPS);

   // The click amplitude divides by five times the step count, the drone by one thousand.
   // Both use a floor reciprocal in Q32 followed by a single correction step.
   localparam logic [9:0]  DEN_CLICK   = 10'(5 * CLICK_STEPS);
   localparam logic [9:0]  DEN_DRONE   = 10'd1000;
   localparam logic [31:0] RECIP_CLICK = 32'((64'd1 << 32) / (5 * CLICK_STEPS));
   localparam logic [31:0] RECIP_DRONE = 32'((64'd1 << 32) / 1000);

   typedef logic signed [15:0] sine_rom_type [ROM_SIZE];
   typedef logic [SINE_ADDR_BITS-1:0] click_addr_type [256];

   // One quarter-wave sine point in Q1.15 from an eleventh-order nested series in Q30.
   function automatic logic [15:0] quarter_sine(input logic [31:0] r);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      x  = (64'd1686629713 * 64'(r)) >> (SINE_ADDR_BITS - 2);
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd110);
      t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd72);
      t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd42);
      t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd20);
      t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd6);
      s  = (x * t) >> 30;
      v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[15:0];
   endfunction

   function automatic sine_rom_type build_sine();
      sine_rom_type rom;
      logic [15:0]  v;
      int           quad;
      int           r;
      for (int i = 0; i < ROM_SIZE; i++) begin
         quad = i / QUARTER;
         r    = i % QUARTER;
         v    = quad[0] ? quarter_sine(32'(QUARTER - r)) : quarter_sine(32'(r));
         rom[i] = quad[1] ? -$signed(v) : $signed(v);
      end
      return rom;
   endfunction

   // Click ROM address per envelope step; the upper half of the table is the downbeat pitch.
   function automatic click_addr_type build_click_addr();
      click_addr_type tab;
      logic [63:0]    fx;
      logic [63:0]    rem;
      for (int i = 0; i < 256; i++) begin
         fx     = (i >= 128) ? 64'd104650 : 64'd52325;
         rem    = (fx * 64'(i % 128)) % CLICK_DEN;
         tab[i] = SINE_ADDR_BITS'((rem << SINE_ADDR_BITS) / CLICK_DEN);
      end
      return tab;
   endfunction

   localparam sine_rom_type   SINE_ROM   = build_sine();
   localparam click_addr_type CLICK_ADDR = build_click_addr();

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLICK_ADDR,
      ST_DRONE_ADDR,
      ST_PIPE1,
      ST_PIPE2,
      ST_PIPE3,
      ST_PIPE4,
      ST_DONE
   } state_type;

   // Configuration registers.
   logic        metronome_enable_ff;
   logic [25:0] tick_increment_ff;
   logic [4:0]  beats_per_bar_ff;
   logic [30:0] drone_increment_ff;
   logic [9:0]  drone_level_ff;

   // Oscillator and FIFO control state.
   state_type        state_ff;
   logic [31:0]      tick_phase_ff;
   logic [6:0]       click_envelope_ff;
   logic [3:0]       beat_count_ff;
   logic [31:0]      drone_phase_ff;
   logic [9:0]       drone_gain_ff;
   logic [9:0]       drone_target_ff;
   logic             drone_on_ff;
   logic [PTR_W-1:0] write_ptr_ff;
   logic [PTR_W-1:0] read_ptr_ff;
   logic [CNT_W-1:0] voice_count_ff;
   logic             clear_pending_ff;

   // Per-render working registers.
   logic        click_active_ff;
   logic [6:0]  click_step_ff;
   logic        click_downbeat_ff;
   logic        drone_active_ff;
   logic        voice_hit_ff;
   logic        fired_ff;
   logic signed [18:0] acc_ff;

   // Memories and their registered read data.
   logic signed [15:0] voice_store [VOICE_DEPTH];
   logic signed [15:0] voice_q_ff;
   logic signed [15:0] rom_q_ff;
   logic [SINE_ADDR_BITS-1:0] rom_addr;
   logic               store_we;

   // Multiply and constant-divide pipeline.
   logic signed [26:0] mul_ff;
   logic               mul_drone_ff;
   logic [25:0]        mag_ff;
   logic [25:0]        quo_ff;
   logic               neg_ff;
   logic               div_drone_ff;
   logic [26:0]        rem_ff;
   logic [25:0]        quo3_ff;
   logic               neg3_ff;
   logic               fix_drone_ff;

   // Result register.
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_mix_ff;
   logic               rsp_push_ff;
   logic               rsp_fired_ff;
   logic               rsp_downbeat_ff;
   logic               rsp_drone_ff;
   logic [FILL_W-1:0]  rsp_fill_ff;

   logic out_free;
   logic accept;
   logic cfg_write;
   logic [2:0] cfg_index;

   // Render step, worked out combinationally from the current state.
   logic [32:0] tick_sum;
   logic        tick_carry;
   logic [4:0]  bar_len;
   logic [4:0]  beat_plus;
   logic [3:0]  beat_next;
   logic [6:0]  env_loaded;
   logic [9:0]  gain_next;
   logic [31:0] drone_phase_next;
   logic        voice_empty;
   logic [PTR_W-1:0] read_next;
   logic [PTR_W-1:0] write_next;

   // Pipeline stage logic.
   logic [10:0]        factor;
   logic [25:0]        mul_mag;
   logic [57:0]        recip_prod;
   logic [35:0]        quo_den;
   logic [9:0]         den2;
   logic [9:0]         den3;
   logic [25:0]        quo_fixed;
   logic signed [18:0] term;
   logic signed [18:0] acc_sum;
   logic signed [15:0] mix_sat;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite;
   assign cfg_index = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (cfg_index)
         REG_METRONOME_ENABLE: csr_prdata = 32'(metronome_enable_ff);
         REG_TICK_INCREMENT:   csr_prdata = 32'(tick_increment_ff);
         REG_BEATS_PER_BAR:    csr_prdata = 32'(beats_per_bar_ff);
         REG_DRONE_INCREMENT:  csr_prdata = 32'(drone_increment_ff);
         REG_DRONE_LEVEL:      csr_prdata = 32'(drone_level_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // Click: a carry out of the tick phase restarts the envelope and advances the beat. A bar
   // length of zero makes every tick a downbeat, lengths above sixteen act as sixteen.
   always_comb begin
      tick_sum   = 33'(tick_phase_ff) + 33'(tick_increment_ff);
      tick_carry = tick_sum[32];
      bar_len    = (beats_per_bar_ff > BAR_MAX) ? BAR_MAX : beats_per_bar_ff;
      beat_plus  = 5'(beat_count_ff) + 5'd1;
      beat_next  = beat_count_ff;
      env_loaded = click_envelope_ff;
      if (metronome_enable_ff && tick_carry) begin
         env_loaded = ENV_START;
         beat_next  = (beat_plus >= bar_len) ? 4'd0 : beat_plus[3:0];
      end
   end

   // Drone gain moves one thousandth per render toward its target.
   always_comb begin
      if (drone_gain_ff < drone_target_ff) begin
         gain_next = drone_gain_ff + 10'd1;
      end else if (drone_gain_ff > drone_target_ff) begin
         gain_next = drone_gain_ff - 10'd1;
      end else begin
         gain_next = drone_gain_ff;
      end
      drone_phase_next = drone_phase_ff + 32'(drone_increment_ff);
   end

   assign voice_empty = clear_pending_ff || (voice_count_ff == '0);
   assign read_next   = (read_ptr_ff == PTR_LAST) ? '0 : read_ptr_ff + PTR_W'(1);
   assign write_next  = (write_ptr_ff == PTR_LAST) ? '0 : write_ptr_ff + PTR_W'(1);
   assign store_we    = accept && (req_operation == OP_PUSH) && (voice_count_ff != CNT_FULL);

   always_ff @(posedge clock) begin
      if (store_we) begin
         voice_store[write_ptr_ff] <= req_voice_sample;
      end
      voice_q_ff <= voice_store[read_ptr_ff];
   end

   // The sine ROM serves the click in the click address state and the drone in the next.
   always_comb begin
      if (state_ff == ST_CLICK_ADDR) begin
         rom_addr = CLICK_ADDR[{click_downbeat_ff, click_step_ff}];
      end else begin
         rom_addr = drone_phase_ff[31 -: SINE_ADDR_BITS];
      end
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= SINE_ROM[rom_addr];
   end

   // Stage one multiplies the sine by the click step times four or by the drone gain. Stage
   // two takes the magnitude times the reciprocal, stage three finds the remainder, and the
   // accumulator applies the correction and the sign.
   always_comb begin
      if (state_ff == ST_DRONE_ADDR) begin
         factor = click_active_ff ? {2'b00, click_step_ff, 2'b00} : '0;
      end else if (state_ff == ST_PIPE1) begin
         factor = drone_active_ff ? {1'b0, drone_gain_ff} : '0;
      end else begin
         factor = '0;
      end
      mul_mag    = mul_ff[26] ? 26'(-mul_ff) : 26'(mul_ff);
      recip_prod = 58'(mul_mag) * 58'(mul_drone_ff ? RECIP_DRONE : RECIP_CLICK);
      den2       = div_drone_ff ? DEN_DRONE : DEN_CLICK;
      quo_den    = 36'(quo_ff) * 36'(den2);
      den3       = fix_drone_ff ? DEN_DRONE : DEN_CLICK;
      quo_fixed  = (rem_ff >= 27'(den3)) ? quo3_ff + 26'd1 : quo3_ff;
      term       = neg3_ff ? -19'(quo_fixed) : 19'(quo_fixed);
      acc_sum    = acc_ff + term;
      if (acc_ff > 19'sd32767) begin
         mix_sat = 16'sh7fff;
      end else if (acc_ff < -19'sd32768) begin
         mix_sat = -16'sh8000;
      end else begin
         mix_sat = acc_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      mul_ff       <= 27'(rom_q_ff * $signed({1'b0, factor}));
      mul_drone_ff <= (state_ff == ST_PIPE1);
      mag_ff       <= mul_mag;
      quo_ff       <= recip_prod[57:32];
      neg_ff       <= mul_ff[26];
      div_drone_ff <= mul_drone_ff;
      rem_ff       <= 27'(mag_ff) - quo_den[26:0];
      quo3_ff      <= quo_ff;
      neg3_ff      <= neg_ff;
      fix_drone_ff <= div_drone_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         metronome_enable_ff <= 1'b0;
         tick_increment_ff   <= TICK_INC_RESET;
         beats_per_bar_ff    <= BEATS_RESET;
         drone_increment_ff  <= '0;
         drone_level_ff      <= LEVEL_RESET;
         tick_phase_ff       <= '0;
         click_envelope_ff   <= '0;
         beat_count_ff       <= '0;
         drone_phase_ff      <= '0;
         drone_gain_ff       <= '0;
         drone_target_ff     <= '0;
         drone_on_ff         <= 1'b0;
         write_ptr_ff        <= '0;
         read_ptr_ff         <= '0;
         voice_count_ff      <= '0;
         clear_pending_ff    <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         click_active_ff     <= 1'b0;
         drone_active_ff     <= 1'b0;
         voice_hit_ff        <= 1'b0;
         fired_ff            <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (cfg_write) begin
            unique case (cfg_index)
               REG_METRONOME_ENABLE: metronome_enable_ff <= csr_pwdata[0];
               REG_TICK_INCREMENT:   tick_increment_ff   <= csr_pwdata[25:0];
               REG_BEATS_PER_BAR:    beats_per_bar_ff    <= csr_pwdata[4:0];
               REG_DRONE_INCREMENT:  drone_increment_ff  <= csr_pwdata[30:0];
               REG_DRONE_LEVEL:      drone_level_ff      <= csr_pwdata[9:0];
               default: ;
            endcase
            if (cfg_index == REG_METRONOME_ENABLE || cfg_index == REG_TICK_INCREMENT ||
                cfg_index == REG_BEATS_PER_BAR) begin
               tick_phase_ff     <= '0;
               click_envelope_ff <= '0;
               beat_count_ff     <= '0;
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rsp_mix_ff      <= '0;
                  rsp_push_ff     <= 1'b0;
                  rsp_fired_ff    <= 1'b0;
                  rsp_downbeat_ff <= (beat_count_ff == 4'd0);
                  rsp_drone_ff    <= drone_on_ff;
                  rsp_fill_ff     <= FILL_W'(voice_count_ff);
                  rsp_valid_ff    <= 1'b1;
                  unique case (req_operation)
                     OP_RENDER: begin
                        rsp_valid_ff <= 1'b0;
                        state_ff     <= ST_CLICK_ADDR;
                        // Click envelope step.
                        fired_ff          <= metronome_enable_ff && tick_carry;
                        click_active_ff   <= metronome_enable_ff && (env_loaded != 7'd0);
                        click_step_ff     <= env_loaded - 7'd1;
                        click_downbeat_ff <= (beat_next == 4'd0);
                        if (metronome_enable_ff) begin
                           tick_phase_ff <= tick_sum[31:0];
                           beat_count_ff <= beat_next;
                           if (env_loaded != 7'd0) begin
                              click_envelope_ff <= env_loaded - 7'd1;
                           end else begin
                              click_envelope_ff <= env_loaded;
                           end
                        end
                        // Drone gain ramp and phase advance.
                        drone_active_ff <= drone_on_ff && (gain_next != 10'd0);
                        if (drone_on_ff) begin
                           drone_gain_ff <= gain_next;
                           if (gain_next != 10'd0) begin
                              drone_phase_ff <= drone_phase_next;
                           end else if (drone_target_ff == 10'd0) begin
                              drone_on_ff <= 1'b0;
                           end
                        end
                        // A pending clear empties the FIFO before this render's pop.
                        voice_hit_ff <= !voice_empty;
                        if (clear_pending_ff) begin
                           write_ptr_ff     <= '0;
                           read_ptr_ff      <= '0;
                           voice_count_ff   <= '0;
                           clear_pending_ff <= 1'b0;
                        end else if (!voice_empty) begin
                           read_ptr_ff    <= read_next;
                           voice_count_ff <= voice_count_ff - CNT_W'(1);
                        end
                     end
                     OP_PUSH: begin
                        if (voice_count_ff != CNT_FULL) begin
                           write_ptr_ff   <= write_next;
                           voice_count_ff <= voice_count_ff + CNT_W'(1);
                           rsp_push_ff    <= 1'b1;
                           rsp_fill_ff    <= FILL_W'(voice_count_ff + CNT_W'(1));
                        end
                     end
                     OP_CLEAR: begin
                        clear_pending_ff <= 1'b1;
                     end
                     OP_DRONE_START: begin
                        drone_phase_ff  <= '0;
                        drone_target_ff <= (drone_level_ff > DRONE_LEVEL_MAX) ?
                                           DRONE_LEVEL_MAX : drone_level_ff;
                        drone_on_ff     <= 1'b1;
                        rsp_drone_ff    <= 1'b1;
                     end
                     OP_DRONE_STOP: begin
                        drone_target_ff <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_CLICK_ADDR: begin
               acc_ff   <= voice_hit_ff ? 19'(voice_q_ff) : '0;
               state_ff <= ST_DRONE_ADDR;
            end
            ST_DRONE_ADDR: begin
               state_ff <= ST_PIPE1;
            end
            ST_PIPE1: begin
               state_ff <= ST_PIPE2;
            end
            ST_PIPE2: begin
               state_ff <= ST_PIPE3;
            end
            ST_PIPE3: begin
               acc_ff   <= acc_sum;
               state_ff <= ST_PIPE4;
            end
            ST_PIPE4: begin
               acc_ff   <= acc_sum;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_mix_ff      <= mix_sat;
                  rsp_push_ff     <= 1'b0;
                  rsp_fired_ff    <= fired_ff;
                  rsp_downbeat_ff <= (beat_count_ff == 4'd0);
                  rsp_drone_ff    <= drone_on_ff;
                  rsp_fill_ff     <= FILL_W'(voice_count_ff);
                  rsp_valid_ff    <= 1'b1;
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mix_sample    = rsp_mix_ff;
   assign rsp_push_accepted = rsp_push_ff;
   assign rsp_tick_fired    = rsp_fired_ff;
   assign rsp_on_downbeat   = rsp_downbeat_ff;
   assign rsp_drone_running = rsp_drone_ff;
   assign rsp_voice_fill    = rsp_fill_ff;

endmodule
